// ----- rtl/x25519_pkg.sv -----
// Shared types and constants for the X25519 scalar multiplier.
// Used by the controller, the datapath and the top level; no dependencies.
package x25519_pkg;

	localparam logic [255:0] PRIME =
		256'h7fffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffed;
	localparam logic [254:0] A24 = 255'd121665;

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_t;

	typedef logic [3:0] src_t;

	// Register file entries, then constant and input operands
	localparam src_t SRC_A    = 4'd0;
	localparam src_t SRC_B    = 4'd1;
	localparam src_t SRC_C    = 4'd2;
	localparam src_t SRC_D    = 4'd3;
	localparam src_t SRC_E    = 4'd4;
	localparam src_t SRC_F    = 4'd5;
	localparam src_t SRC_X    = 4'd6;
	localparam src_t SRC_T    = 4'd7;
	localparam src_t SRC_ONE  = 4'd8;
	localparam src_t SRC_ZERO = 4'd9;
	localparam src_t SRC_A24  = 4'd10;
	localparam src_t SRC_PT   = 4'd11;

	typedef struct packed {
		logic       start;
		op_t        op;
		logic [2:0] dst;
		src_t       src1;
		src_t       src2;
		logic       pt_we;
		logic [1:0] pt_idx;
		logic [1:0] out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

endpackage

// ----- rtl/x25519_fmul.sv -----
// Multi-cycle multiplier modulo 2^255-19: 64 limb products on one 32x32 multiplier,
// limb-serial fold of the high half by 38, then final reduction. Uses x25519_pkg.
module x25519_fmul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [254:0] a,
	input  logic [254:0] b,
	output logic         done,
	output logic [254:0] p
);
	import x25519_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_MUL, M_DRAIN, M_RED, M_FOLD1, M_FOLD2, M_FOLD3, M_FIN
	} mstate_t;

	mstate_t      state_q;
	logic [2:0]   i_q, j_q, k_q;
	logic         v_s1;
	logic         done_q;
	logic [255:0] a_q, b_q;
	logic [63:0]  prod_s1;
	logic [2:0]   i_s1, j_s1;
	logic [511:0] rr_q;
	logic [31:0]  carry_q;
	logic [5:0]   c_q;
	logic [255:0] v_q;
	logic [254:0] p_q;

	logic [31:0]  alimb, blimb, rlimb;
	logic [63:0]  prod, cin, acc;
	logic [3:0]   idx;
	logic [37:0]  red;
	logic [6:0]   top;
	logic [11:0]  t19;
	logic [255:0] tfin;

	assign alimb = a_q[{i_q, 5'b0} +: 32];
	assign blimb = b_q[{j_q, 5'b0} +: 32];
	assign prod  = alimb * blimb;
	assign idx   = {1'b0, i_s1} + {1'b0, j_s1};
	assign rlimb = rr_q[{idx, 5'b0} +: 32];
	assign cin   = (j_s1 == 3'd0) ? 64'd0 : {32'b0, carry_q};
	assign acc   = prod_s1 + {32'b0, rlimb} + cin;
	assign red   = 38'(rr_q[31:0]) + 38'(rr_q[287:256]) * 38'd38 + 38'(c_q);
	assign top   = {c_q, rr_q[255]};
	assign t19   = 12'(top) * 12'd19;
	assign tfin  = v_q + 256'd19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1   <= (state_q == M_MUL);
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
						i_q     <= '0;
						j_q     <= '0;
					end
				end
				M_MUL: begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd7) begin
						i_q <= i_q + 3'd1;
						if (i_q == 3'd7) state_q <= M_DRAIN;
					end
				end
				M_DRAIN: begin
					state_q <= M_RED;
					k_q     <= '0;
				end
				M_RED: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) state_q <= M_FOLD1;
				end
				M_FOLD1: state_q <= M_FOLD2;
				M_FOLD2: state_q <= M_FOLD3;
				M_FOLD3: state_q <= M_FIN;
				M_FIN: begin
					state_q <= M_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		i_s1    <= i_q;
		j_s1    <= j_q;
		if (state_q == M_IDLE && start) begin
			a_q  <= {1'b0, a};
			b_q  <= {1'b0, b};
			rr_q <= '0;
		end
		if (v_s1) begin
			rr_q[{idx, 5'b0} +: 32] <= acc[31:0];
			if (j_s1 == 3'd7) rr_q[{idx + 4'd1, 5'b0} +: 32] <= acc[63:32];
			carry_q <= acc[63:32];
		end
		if (state_q == M_DRAIN) c_q <= '0;
		if (state_q == M_RED) begin
			// fold one high limb by 38 and rotate the low half
			rr_q <= {32'b0, rr_q[511:288], red[31:0], rr_q[255:32]};
			c_q  <= red[37:32];
		end
		if (state_q == M_FOLD1) v_q <= {1'b0, rr_q[254:0]} + {244'b0, t19};
		if (state_q == M_FOLD2 || state_q == M_FOLD3)
			v_q <= {1'b0, v_q[254:0]} + (v_q[255] ? 256'd19 : 256'd0);
		if (state_q == M_FIN) p_q <= tfin[255] ? tfin[254:0] : v_q[254:0];
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// ----- rtl/x25519_ctrl.sv -----
// Sequencer for the ladder, the inversion and the result transactions.
// Holds the scalar registers; drives the datapath through dp_cmd_t. Uses x25519_pkg.
module x25519_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_wdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [1:0]          m_axis_tuser,
	output logic                m_axis_tlast,
	output x25519_pkg::dp_cmd_t cmd,
	input  x25519_pkg::dp_stat_t stat
);
	import x25519_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_OUT} cstate_t;
	typedef enum logic [1:0] {PH_INIT, PH_LADDER, PH_INV, PH_FINAL} phase_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] dst;
		src_t       s1;
		src_t       s2;
	} uop_t;

	function automatic uop_t mk(op_t op, src_t d, src_t s1, src_t s2);
		uop_t u;
		u.op  = op;
		u.dst = d[2:0];
		u.s1  = s1;
		u.s2  = s2;
		return u;
	endfunction

	function automatic uop_t init_uop(logic [2:0] pc);
		uop_t u;
		case (pc)
			3'd0:    u = mk(OP_ADD, SRC_X, SRC_PT, SRC_ZERO);
			3'd1:    u = mk(OP_ADD, SRC_B, SRC_X, SRC_ZERO);
			3'd2:    u = mk(OP_ADD, SRC_A, SRC_ONE, SRC_ZERO);
			3'd3:    u = mk(OP_ADD, SRC_C, SRC_ZERO, SRC_ZERO);
			default: u = mk(OP_ADD, SRC_D, SRC_ONE, SRC_ZERO);
		endcase
		return u;
	endfunction

	function automatic uop_t ladder_uop(logic [4:0] pc);
		uop_t u;
		case (pc)
			5'd0:    u = mk(OP_ADD, SRC_E, SRC_A, SRC_C);
			5'd1:    u = mk(OP_SUB, SRC_A, SRC_A, SRC_C);
			5'd2:    u = mk(OP_ADD, SRC_C, SRC_B, SRC_D);
			5'd3:    u = mk(OP_SUB, SRC_B, SRC_B, SRC_D);
			5'd4:    u = mk(OP_MUL, SRC_D, SRC_E, SRC_E);
			5'd5:    u = mk(OP_MUL, SRC_F, SRC_A, SRC_A);
			5'd6:    u = mk(OP_MUL, SRC_A, SRC_C, SRC_A);
			5'd7:    u = mk(OP_MUL, SRC_C, SRC_B, SRC_E);
			5'd8:    u = mk(OP_ADD, SRC_E, SRC_A, SRC_C);
			5'd9:    u = mk(OP_SUB, SRC_A, SRC_A, SRC_C);
			5'd10:   u = mk(OP_MUL, SRC_B, SRC_A, SRC_A);
			5'd11:   u = mk(OP_SUB, SRC_C, SRC_D, SRC_F);
			5'd12:   u = mk(OP_MUL, SRC_A, SRC_C, SRC_A24);
			5'd13:   u = mk(OP_ADD, SRC_A, SRC_A, SRC_D);
			5'd14:   u = mk(OP_MUL, SRC_C, SRC_C, SRC_A);
			5'd15:   u = mk(OP_MUL, SRC_A, SRC_D, SRC_F);
			5'd16:   u = mk(OP_MUL, SRC_D, SRC_B, SRC_X);
			default: u = mk(OP_MUL, SRC_B, SRC_E, SRC_E);
		endcase
		return u;
	endfunction

	// rename A<->B and C<->D instead of swapping values
	function automatic src_t remap(src_t s, logic swp);
		return (s[3:2] == 2'b00) ? {s[3:1], s[0] ^ swp} : s;
	endfunction

	cstate_t      state_q;
	phase_t       ph_q;
	logic [4:0]   pc_q;
	logic [7:0]   step_q, inv_i_q;
	logic         inv_mul_q, pend_q;
	logic [1:0]   out_q;
	logic [63:0]  scalar_q [4];
	logic [255:0] kc;
	logic         swp, in_acc, start_word;
	uop_t         u;
	src_t         dmap;

	assign kc = {1'b0, 1'b1, scalar_q[3][61:0], scalar_q[2], scalar_q[1],
		scalar_q[0][63:3], 3'b000};
	assign swp = (ph_q == PH_LADDER) && kc[step_q];

	assign s_axis_tready = (state_q == C_IDLE) || (state_q == C_OUT && !pend_q);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign start_word    = in_acc && (s_axis_tuser == 2'd3);

	always_comb begin
		case (ph_q)
			PH_INIT:   u = init_uop(pc_q[2:0]);
			PH_LADDER: u = ladder_uop(pc_q);
			PH_INV: begin
				if (pc_q == 5'd0)    u = mk(OP_ADD, SRC_T, SRC_C, SRC_ZERO);
				else if (!inv_mul_q) u = mk(OP_MUL, SRC_T, SRC_T, SRC_T);
				else                 u = mk(OP_MUL, SRC_T, SRC_T, SRC_C);
			end
			default:   u = mk(OP_MUL, SRC_A, SRC_A, SRC_T);
		endcase
	end

	assign dmap = remap({1'b0, u.dst}, swp);

	always_comb begin
		cmd.start   = (state_q == C_ISSUE);
		cmd.op      = u.op;
		cmd.dst     = dmap[2:0];
		cmd.src1    = remap(u.s1, swp);
		cmd.src2    = remap(u.s2, swp);
		cmd.pt_we   = in_acc;
		cmd.pt_idx  = s_axis_tuser;
		cmd.out_sel = out_q;
	end

	assign m_axis_tvalid = (state_q == C_OUT);
	assign m_axis_tuser  = out_q;
	assign m_axis_tlast  = (out_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 4; n++) scalar_q[n] <= '0;
		end else if (cfg_we) begin
			scalar_q[cfg_index] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_IDLE;
			ph_q      <= PH_INIT;
			pc_q      <= '0;
			step_q    <= '0;
			inv_i_q   <= '0;
			inv_mul_q <= 1'b0;
			pend_q    <= 1'b0;
			out_q     <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start_word) begin
						state_q <= C_ISSUE;
						ph_q    <= PH_INIT;
						pc_q    <= '0;
					end
				end
				C_ISSUE: state_q <= C_WAIT;
				C_WAIT: begin
					if (stat.done) begin
						state_q <= C_ISSUE;
						case (ph_q)
							PH_INIT: begin
								if (pc_q == 5'd4) begin
									ph_q   <= PH_LADDER;
									pc_q   <= '0;
									step_q <= 8'd254;
								end else begin
									pc_q <= pc_q + 5'd1;
								end
							end
							PH_LADDER: begin
								if (pc_q == 5'd17) begin
									pc_q <= '0;
									if (step_q == 8'd0) ph_q <= PH_INV;
									else step_q <= step_q - 8'd1;
								end else begin
									pc_q <= pc_q + 5'd1;
								end
							end
							PH_INV: begin
								if (pc_q == 5'd0) begin
									pc_q      <= 5'd1;
									inv_i_q   <= 8'd253;
									inv_mul_q <= 1'b0;
								end else if (!inv_mul_q && inv_i_q != 8'd2 && inv_i_q != 8'd4) begin
									inv_mul_q <= 1'b1;
								end else begin
									inv_mul_q <= 1'b0;
									if (inv_i_q == 8'd0) ph_q <= PH_FINAL;
									else inv_i_q <= inv_i_q - 8'd1;
								end
							end
							default: begin
								state_q <= C_OUT;
								out_q   <= '0;
							end
						endcase
					end
				end
				C_OUT: begin
					if (start_word) pend_q <= 1'b1;
					if (m_axis_tready) begin
						if (out_q == 2'd3) begin
							pend_q <= 1'b0;
							out_q  <= '0;
							if (pend_q || start_word) begin
								state_q <= C_ISSUE;
								ph_q    <= PH_INIT;
								pc_q    <= '0;
							end else begin
								state_q <= C_IDLE;
							end
						end else begin
							out_q <= out_q + 2'd1;
						end
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/x25519_dp.sv -----
// Field datapath: 8-entry register file, point store, add/sub unit and multiplier.
// Executes one dp_cmd_t operation at a time. Uses x25519_pkg and x25519_fmul.
module x25519_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  x25519_pkg::dp_cmd_t  cmd,
	input  logic [63:0]          point_word,
	output x25519_pkg::dp_stat_t stat,
	output logic [63:0]          shared_word
);
	import x25519_pkg::*;

	typedef enum logic [2:0] {D_IDLE, D_LD, D_EX, D_AS, D_MW} dstate_t;

	dstate_t      state_q;
	logic         done_q, mstart_q;
	op_t          op_q;
	logic [2:0]   dst_q;
	src_t         s1_q, s2_q;
	logic [254:0] rf [8];
	logic [254:0] rd1_q, rd2_q, opa_q, opb_q, res_q;
	logic [63:0]  pt_q [4];
	logic [255:0] raw_q;

	logic [254:0] pt, wdata, cor, mp;
	logic [256:0] dsub;
	logic [255:0] addp, res_ext;
	logic         we, mdone;

	function automatic logic [254:0] pick(src_t s, logic [254:0] r, logic [254:0] ptv);
		logic [254:0] v;
		case (s)
			SRC_ONE:  v = 255'd1;
			SRC_ZERO: v = '0;
			SRC_A24:  v = A24;
			SRC_PT:   v = ptv;
			default:  v = r;
		endcase
		return v;
	endfunction

	assign pt   = {pt_q[3][62:0], pt_q[2], pt_q[1], pt_q[0]};
	assign dsub = {1'b0, raw_q} - {1'b0, PRIME};
	assign addp = raw_q + PRIME;
	assign cor  = (op_q == OP_ADD) ? (dsub[256] ? raw_q[254:0] : dsub[254:0])
		: (raw_q[255] ? addp[254:0] : raw_q[254:0]);
	assign we    = (state_q == D_AS) || (state_q == D_MW && mdone);
	assign wdata = (state_q == D_AS) ? cor : mp;

	x25519_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.a      (opa_q),
		.b      (opb_q),
		.done   (mdone),
		.p      (mp)
	);

	always_ff @(posedge clk) begin
		if (we) rf[dst_q] <= wdata;
		rd1_q <= rf[cmd.src1[2:0]];
		rd2_q <= rf[cmd.src2[2:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.pt_we) pt_q[cmd.pt_idx] <= point_word;
		if (state_q == D_IDLE && cmd.start) begin
			op_q  <= cmd.op;
			dst_q <= cmd.dst;
			s1_q  <= cmd.src1;
			s2_q  <= cmd.src2;
		end
		if (state_q == D_LD) begin
			opa_q <= pick(s1_q, rd1_q, pt);
			opb_q <= pick(s2_q, rd2_q, pt);
		end
		if (state_q == D_EX)
			raw_q <= (op_q == OP_ADD) ? ({1'b0, opa_q} + {1'b0, opb_q})
				: ({1'b0, opa_q} - {1'b0, opb_q});
		if (we) res_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= D_IDLE;
			done_q   <= 1'b0;
			mstart_q <= 1'b0;
		end else begin
			done_q   <= we;
			mstart_q <= 1'b0;
			case (state_q)
				D_IDLE: if (cmd.start) state_q <= D_LD;
				D_LD: begin
					if (op_q == OP_MUL) begin
						state_q  <= D_MW;
						mstart_q <= 1'b1;
					end else begin
						state_q <= D_EX;
					end
				end
				D_EX: state_q <= D_AS;
				D_AS: state_q <= D_IDLE;
				D_MW: if (mdone) state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign stat.done   = done_q;
	assign res_ext     = {1'b0, res_q};
	assign shared_word = res_ext[{cmd.out_sel, 6'b0} +: 64];

endmodule

// ----- rtl/x25519_scalar_multiply.sv -----
// X25519 scalar multiplication, top level: controller plus field datapath.
// Depends on x25519_pkg, x25519_ctrl, x25519_dp (and x25519_fmul below it).
//
// Usage: write the 256-bit scalar through cfg_we/cfg_index/cfg_wdata (index 0 is
// the low word); it is clamped internally. Send the u-coordinate on s_axis as
// four 64-bit transactions with the word position in tuser; the transaction with
// position 3 starts the computation (bit 255 of u is ignored).
// The result appears on m_axis as four transactions, low word first, position in
// tuser, tlast on the fourth.
// Each field multiplication runs on the single 32x32 multiplier, which issues one
// limb product per cycle. A ladder step holds 10 multiplications and 8 add/subs.
// One key is processed at a time.
// While results wait for m_axis_tready the block holds them and still takes input
// words; a position-3 word taken then starts the next key after the fourth result.
// Reset clears the scalar registers and all control state; input words must be
// resent after reset.
module x25519_scalar_multiply (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] point_word
	input  logic [1:0]  s_axis_tuser,   // [1:0] word_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] shared_word
	output logic [1:0]  m_axis_tuser,   // [1:0] out_index
	output logic        m_axis_tlast
);
	import x25519_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	x25519_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.stat          (stat)
	);

	x25519_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.point_word  (s_axis_tdata),
		.stat        (stat),
		.shared_word (m_axis_tdata)
	);

endmodule

// ----- rtl/x25519_chk.sv -----
// Port-level checks for x25519_scalar_multiply, bound to the top level.
// Depends only on the top-level ports.
module x25519_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
		else $error("tlast not on fourth word");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1)
		else $error("result words not contiguous");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("result after last word");

	// a starting word blocks further input until its key is under way
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == 2'd3 |=> !s_axis_tready)
		else $error("input taken right after a starting word");

endmodule

bind x25519_scalar_multiply x25519_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- sim/testbench.sv -----
// Self-checking bench for the X25519 scalar multiplier: drives u-coordinate words
// on s_axis, predicts each shared key and checks the m_axis words.
// Depends on x25519_pkg and the x25519_scalar_multiply RTL.
module testbench;
	import x25519_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
	localparam logic [255:0] FIELD_P = {1'b0, {250{1'b1}}, 5'b01101};
	localparam logic [254:0] A24_VAL = 255'd121665;

	typedef struct {
		logic [63:0] word;
		logic [1:0]  index;
		logic        last;
	} key_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;    // [63:0] point_word
	logic [1:0]  s_axis_tuser = '0;    // [1:0] word_index
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // [63:0] shared_word
	logic [1:0]  m_axis_tuser;         // [1:0] out_index
	logic        m_axis_tlast;

	logic [63:0]    scalar_regs[4];
	logic [63:0]    u_words[4];
	key_word_t      pending_keys[$];
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             errors = 0;
	longint unsigned cycles = 0;

	x25519_scalar_multiply DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// compare each result transaction with the oldest predicted word
	always @(posedge clk) begin
		key_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_keys.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h idx %0d last %0b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				exp_w = pending_keys.pop_front();
				if (m_axis_tdata !== exp_w.word || m_axis_tuser !== exp_w.index
						|| m_axis_tlast !== exp_w.last) begin
					errors++;
					$display("%0t: expected %h idx %0d last %0b, got %h idx %0d last %0b",
						$time, exp_w.word, exp_w.index, exp_w.last,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end
			end
		end
	end

	function automatic logic [255:0] fmul(logic [255:0] a, logic [255:0] b);
		logic [511:0] wa;
		logic [511:0] wb;
		logic [511:0] wr;
		wa = a;
		wb = b;
		wr = (wa * wb) % {256'd0, FIELD_P};
		return wr[255:0];
	endfunction

	function automatic logic [255:0] fadd(logic [255:0] a, logic [255:0] b);
		return (a + b) % FIELD_P;
	endfunction

	function automatic logic [255:0] fsub(logic [255:0] a, logic [255:0] b);
		return (a + FIELD_P - b) % FIELD_P;
	endfunction

	function automatic logic [255:0] shared_key();
		logic [255:0] k;
		logic [255:0] x1;
		logic [255:0] x2;
		logic [255:0] z2;
		logic [255:0] x3;
		logic [255:0] z3;
		logic [255:0] ta;
		logic [255:0] aa;
		logic [255:0] tb;
		logic [255:0] bb;
		logic [255:0] te;
		logic [255:0] da;
		logic [255:0] cb;
		logic [255:0] tmp;
		logic [255:0] inv;
		logic [255:0] ex;
		logic         bit_k;
		k = {scalar_regs[3], scalar_regs[2], scalar_regs[1], scalar_regs[0]};
		k[2:0] = 3'b000;
		k[255] = 1'b0;
		k[254] = 1'b1;
		x1 = {1'b0, u_words[3][62:0], u_words[2], u_words[1], u_words[0]};
		x1 = x1 % FIELD_P;
		x2 = 256'd1;
		z2 = 256'd0;
		x3 = x1;
		z3 = 256'd1;
		for (int i = 254; i >= 0; i--) begin
			bit_k = k[i];
			if (bit_k) begin
				tmp = x2; x2 = x3; x3 = tmp;
				tmp = z2; z2 = z3; z3 = tmp;
			end
			ta = fadd(x2, z2);
			aa = fmul(ta, ta);
			tb = fsub(x2, z2);
			bb = fmul(tb, tb);
			te = fsub(aa, bb);
			da = fmul(fsub(x3, z3), ta);
			cb = fmul(fadd(x3, z3), tb);
			tmp = fadd(da, cb);
			x3 = fmul(tmp, tmp);
			tmp = fsub(da, cb);
			z3 = fmul(x1, fmul(tmp, tmp));
			x2 = fmul(aa, bb);
			z2 = fmul(te, fadd(aa, fmul({1'b0, A24_VAL}, te)));
			if (bit_k) begin
				tmp = x2; x2 = x3; x3 = tmp;
				tmp = z2; z2 = z3; z3 = tmp;
			end
		end
		// z^(p-2); zero stays zero
		ex = FIELD_P - 256'd2;
		inv = 256'd1;
		for (int i = 255; i >= 0; i--) begin
			inv = fmul(inv, inv);
			if (ex[i])
				inv = fmul(inv, z2);
		end
		return fmul(x2, inv);
	endfunction

	task automatic send_point_word(logic [63:0] word, logic [1:0] index);
		logic [255:0] key;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= index;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		u_words[index] = word;
		if (index == 2'd3) begin
			key = shared_key();
			for (int k = 0; k < 4; k++)
				pending_keys.push_back('{key[64*k +: 64], 2'(k), k == 3});
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_point(logic [255:0] u);
		for (int i = 0; i < 4; i++)
			send_point_word(u[64*i +: 64], 2'(i));
	endtask

	// hold until every key has come back and the block has gone quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_keys.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_scalar(logic [255:0] k);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_wdata <= k[64*i +: 64];
			scalar_regs[i] = k[64*i +: 64];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_directed();
		// reset scalar of zero clamps to 2^254
		send_point(256'd9);
		drain();
		write_scalar('1);
		send_point(256'd0);                // z ends at zero
		send_point({1'b0, FIELD_P[254:0]}); // non-canonical, reduces to zero
		send_point('1);                     // bit 255 set, then non-canonical
		drain();
		write_scalar({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		send_point(256'd1);
		send_point(FIELD_P - 256'd1);
		drain();
	endtask

	task automatic test_random_keys(int idle_pct, int stall_pct);
		logic [255:0] u;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_scalar({rand_word(), rand_word(), rand_word(), rand_word()});
		for (int n = 0; n < 5; n++) begin
			if ($urandom_range(3) != 0) begin
				u = {rand_word(), rand_word(), rand_word(), rand_word()};
				send_point(u);
			end else begin
				// stray words, then a recompute on whatever is stored
				repeat ($urandom_range(1, 3))
					send_point_word(rand_word(), 2'($urandom_range(2)));
				send_point_word(rand_word(), 2'd3);
			end
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < 4; i++) begin
			scalar_regs[i] = '0;
			u_words[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_keys(0, 0);
		test_random_keys(70, 0);
		test_random_keys(0, 70);
		test_random_keys(26, 26);
		if (errors == 0 && pending_keys.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
